FILE: sv/cfc_pkg.sv
`default_nettype none

package cfc_pkg;

  // Galois feedback mask for taps 32, 31, 29 and 1.
  localparam logic [31:0] LfsrTaps = 32'hD000_0001;

  // Reset values of the configuration registers.
  localparam logic [15:0] OnSecondsRst      = 16'd7200;
  localparam logic [15:0] TicksPerSecondRst = 16'd285;
  localparam logic [15:0] HoldTicksRst      = 16'd570;
  localparam logic [3:0]  DelayShiftRst     = 4'd7;
  localparam logic [31:0] LfsrSeedRst       = 32'hBEEF_CACE;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] RegOnSeconds      = 3'd0;
  localparam logic [CfgIdxW-1:0] RegTicksPerSecond = 3'd1;
  localparam logic [CfgIdxW-1:0] RegHoldTicks      = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDelayShift     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLfsrSeed       = 3'd4;

  // Register set shared by the top level and the update core.
  typedef struct packed {
    logic [15:0] on_seconds;
    logic [15:0] ticks_per_second;
    logic [15:0] hold_ticks;
    logic [3:0]  delay_shift;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic       off_pending;
    logic       asleep;
    logic [3:0] led_lit;
  } result_t;

endpackage

`default_nettype wire

FILE: sv/cfc_core.sv
`default_nettype none

module cfc_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cfc_pkg::cfg_t    cfg_i,
  input  wire logic             seed_load_i,
  input  wire logic [31:0]      seed_i,
  input  wire logic             step_i,
  input  wire logic             timer_tick_i,
  input  wire logic             button_pressed_i,
  output cfc_pkg::result_t      result_o
);

  logic [31:0] lfsr_q, lfsr_d;
  logic [15:0] prescale_q, prescale_d;
  logic [15:0] seconds_q, seconds_d;
  logic [15:0] hold_q, hold_d;
  logic        off_req_q, off_req_d;
  logic        sleep_q, sleep_d;
  logic        last_btn_q;
  logic [16:0] wait_q, wait_d;
  logic [3:0]  pattern_q, pattern_d;

  logic [15:0] prescale_inc;
  logic [31:0] lfsr_next;
  logic [15:0] wait_raw;

  // Next LFSR value and the flicker wait derived from its top byte.
  always_comb begin
    lfsr_next = (lfsr_q >> 1) ^ ({32{lfsr_q[0]}} & cfc_pkg::LfsrTaps);
    wait_raw  = 16'({8'h00, lfsr_next[31:24]} << cfg_i.delay_shift);
  end

  assign prescale_inc = prescale_q + 16'd1;

  // Per-unit state update: tick counting, sleep decisions, flicker step.
  always_comb begin
    lfsr_d     = lfsr_q;
    prescale_d = prescale_q;
    seconds_d  = seconds_q;
    hold_d     = hold_q;
    off_req_d  = off_req_q;
    sleep_d    = sleep_q;
    wait_d     = wait_q;
    pattern_d  = pattern_q;

    if (sleep_q) begin
      // Any change of the button level wakes the block, nothing else runs.
      if (button_pressed_i != last_btn_q) begin
        sleep_d = 1'b0;
      end
    end else begin
      if (timer_tick_i) begin
        if (prescale_inc == cfg_i.ticks_per_second) begin
          prescale_d = '0;
          seconds_d  = seconds_q + 16'd1;
        end else begin
          prescale_d = prescale_inc;
        end
        hold_d = button_pressed_i ? hold_q + 16'd1 : '0;

        if ((cfg_i.on_seconds != '0) && (seconds_d >= cfg_i.on_seconds) &&
            !button_pressed_i) begin
          seconds_d = '0;
          off_req_d = 1'b0;
          hold_d    = '0;
          sleep_d   = 1'b1;
          pattern_d = '0;
        end else if (hold_d == cfg_i.hold_ticks) begin
          off_req_d = 1'b1;
        end else if (off_req_q && !button_pressed_i) begin
          off_req_d = 1'b0;
          sleep_d   = 1'b1;
          pattern_d = '0;
        end
      end

      // Flicker runs only if this unit did not put the block to sleep.
      if (!sleep_d) begin
        if (wait_q != '0) begin
          wait_d = wait_q - 17'd1;
        end else begin
          lfsr_d    = lfsr_next;
          pattern_d = off_req_d ? 4'b0000 : {1'b1, ~lfsr_next[2:0]};
          wait_d    = (wait_raw == '0) ? 17'h1_0000 : {1'b0, wait_raw};
        end
      end
    end
  end

  // State registers; a seed write reloads the generator.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q     <= cfc_pkg::LfsrSeedRst;
      prescale_q <= '0;
      seconds_q  <= '0;
      hold_q     <= '0;
      off_req_q  <= 1'b0;
      sleep_q    <= 1'b0;
      last_btn_q <= 1'b0;
      wait_q     <= '0;
      pattern_q  <= '0;
    end else if (seed_load_i) begin
      lfsr_q <= seed_i;
    end else if (step_i) begin
      lfsr_q     <= lfsr_d;
      prescale_q <= prescale_d;
      seconds_q  <= seconds_d;
      hold_q     <= hold_d;
      off_req_q  <= off_req_d;
      sleep_q    <= sleep_d;
      last_btn_q <= button_pressed_i;
      wait_q     <= wait_d;
      pattern_q  <= pattern_d;
    end
  end

  // Result of the unit being processed.
  always_comb begin
    result_o.led_lit     = sleep_d ? 4'b0000 : pattern_d;
    result_o.asleep      = sleep_d;
    result_o.off_pending = off_req_d;
  end

endmodule

`default_nettype wire

FILE: sv/candle_flicker_controller.sv
// Candle flicker controller.
// Input stream: one request per fine time unit, carrying the timer tick flag
// and the button level. Output stream: one request per input request with
// the LED drive, the sleep flag and the pending switch-off flag.
// An accepted input is held in an input register; once the output register
// is free, the update core advances its state and the result is written to
// the output register. Throughput is one request per cycle while the
// receiver does not stall.
// When the receiver stalls, the output register holds its result and the
// input register absorbs one more request before s_axis_tready drops.
// A configuration write to the seed also reloads the random generator.
// Writes must be made while the stream is idle; the block itself does not
// enforce this.
// Reset restores the default registers, clears the counters, leaves the
// block awake with all LEDs dark and makes the first unit run a flicker
// step at once.
`default_nettype none

module candle_flicker_controller (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [0] timer_tick, [1] button_pressed
  // Output stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [3:0] led_lit, [4] asleep,
                                           // [5] off_pending
  // Configuration write port.
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  cfc_pkg::cfg_t    cfg_q;
  cfc_pkg::result_t result;

  logic       in_valid_q;
  logic       in_tick_q;
  logic       in_btn_q;
  logic       out_valid_q;
  logic [5:0] out_data_q;
  logic       advance;
  logic       seed_load;

  // The input register moves on when the output register is free.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign seed_load     = cfg_we_i && (cfg_index_i == cfc_pkg::RegLfsrSeed);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.on_seconds       <= cfc_pkg::OnSecondsRst;
      cfg_q.ticks_per_second <= cfc_pkg::TicksPerSecondRst;
      cfg_q.hold_ticks       <= cfc_pkg::HoldTicksRst;
      cfg_q.delay_shift      <= cfc_pkg::DelayShiftRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        cfc_pkg::RegOnSeconds:      cfg_q.on_seconds       <= cfg_data_i[15:0];
        cfc_pkg::RegTicksPerSecond: cfg_q.ticks_per_second <= cfg_data_i[15:0];
        cfc_pkg::RegHoldTicks:      cfg_q.hold_ticks       <= cfg_data_i[15:0];
        cfc_pkg::RegDelayShift:     cfg_q.delay_shift      <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_tick_q <= s_axis_tdata[0];
      in_btn_q  <= s_axis_tdata[1];
    end
  end

  cfc_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .seed_load_i      (seed_load),
    .seed_i           (cfg_data_i),
    .step_i           (advance),
    .timer_tick_i     (in_tick_q),
    .button_pressed_i (in_btn_q),
    .result_o         (result)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_data_q};

endmodule

`default_nettype wire
